### design/vtp_pkg.sv
package vtp_pkg;

   // field widths
   localparam int COORD_W   = 24;
   localparam int WGT_W     = 16;
   localparam int WGT_ROW_W = 3 * WGT_W;
   localparam int OFF_W     = 20;
   localparam int OFF_ROW_W = 3 * OFF_W;
   localparam int FOCAL_W   = 10;
   localparam int CENTER_W  = 12;
   localparam int SCREEN_W  = 16;
   localparam int QUOT_BITS = SCREEN_W;
   localparam int PROD_W    = COORD_W + WGT_W;

   localparam int COEF_FRAC_BITS_DEF = 14;

   // config port
   localparam int NUM_REGS   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = OFF_ROW_W;

   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]      csr_data_type;
   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [SCREEN_W-1:0] screen_type;

   localparam csr_idx_type REG_WEIGHTS_X = 3'd0;
   localparam csr_idx_type REG_WEIGHTS_Y = 3'd1;
   localparam csr_idx_type REG_WEIGHTS_Z = 3'd2;
   localparam csr_idx_type REG_OFFSET    = 3'd3;
   localparam csr_idx_type REG_FOCAL     = 3'd4;
   localparam csr_idx_type REG_CENTER_X  = 3'd5;
   localparam csr_idx_type REG_CENTER_Y  = 3'd6;

   // identity view matrix at reset: 1.0 in Q1.14 on the diagonal
   localparam logic [WGT_ROW_W-1:0] WEIGHTS_X_RST = 48'h0000_0000_4000;
   localparam logic [WGT_ROW_W-1:0] WEIGHTS_Y_RST = 48'h0000_4000_0000;
   localparam logic [WGT_ROW_W-1:0] WEIGHTS_Z_RST = 48'h4000_0000_0000;
   localparam logic [OFF_ROW_W-1:0] OFFSET_RST    = '0;
   localparam logic [FOCAL_W-1:0]   FOCAL_RST     = 10'd80;
   localparam logic [CENTER_W-1:0]  CENTER_X_RST  = 12'd320;
   localparam logic [CENTER_W-1:0]  CENTER_Y_RST  = 12'd240;

   // control that rides along with each beat
   typedef struct packed {
      logic valid;
      logic behind;
   } vtp_ctl_type;

endpackage

### design/vtp_div.sv
// Pipelined signed divide of two numerators by one positive divisor,
// one quotient bit per stage, truncating toward zero, saturated to screen range.
module vtp_div #(
   parameter int NUM_W = 57,
   parameter int DEN_W = 43
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  vtp_pkg::vtp_ctl_type      in_ctl,
   input  logic signed [NUM_W-1:0]   in_num_x,
   input  logic signed [NUM_W-1:0]   in_num_y,
   input  logic [DEN_W-1:0]          in_den,
   output vtp_pkg::vtp_ctl_type      out_ctl,
   output vtp_pkg::screen_type       out_scr_x,
   output vtp_pkg::screen_type       out_scr_y
);
   import vtp_pkg::*;

   localparam int QB    = QUOT_BITS;
   localparam int REM_W = DEN_W + QB;
   localparam int CMP_W = (NUM_W > REM_W) ? NUM_W : REM_W;
   localparam logic [QB-1:0] POS_LIMIT = {1'b0, {(QB-1){1'b1}}};
   localparam logic [QB-1:0] NEG_LIMIT = {1'b1, {(QB-1){1'b0}}};

   function automatic screen_type sat_quot(input logic neg, input logic ovf,
                                           input logic [QB-1:0] q);
      screen_type r;
      if (neg) begin
         if (ovf || q > NEG_LIMIT) r = screen_type'(NEG_LIMIT);
         else                     r = screen_type'(-$signed({1'b0, q}));
      end else begin
         if (ovf || q > POS_LIMIT) r = screen_type'(POS_LIMIT);
         else                     r = screen_type'(q);
      end
      return r;
   endfunction

   // stage A: sign and magnitude
   vtp_ctl_type      a_ctl_ff;
   logic             a_negx_ff, a_negy_ff;
   logic [NUM_W-1:0] a_magx_ff, a_magy_ff;
   logic [DEN_W-1:0] a_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (en) begin
         a_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_negx_ff <= in_num_x[NUM_W-1];
         a_negy_ff <= in_num_y[NUM_W-1];
         a_magx_ff <= in_num_x[NUM_W-1] ? $unsigned(-in_num_x) : $unsigned(in_num_x);
         a_magy_ff <= in_num_y[NUM_W-1] ? $unsigned(-in_num_y) : $unsigned(in_num_y);
         a_den_ff  <= in_den;
      end
   end

   // stage B (index 0) and the bit steps (1..QB)
   vtp_ctl_type      ctl_ff  [QB+1];
   logic [DEN_W-1:0] den_ff  [QB+1];
   logic             negx_ff [QB+1];
   logic             negy_ff [QB+1];
   logic             ovfx_ff [QB+1];
   logic             ovfy_ff [QB+1];
   logic [REM_W-1:0] remx_ff [QB+1];
   logic [REM_W-1:0] remy_ff [QB+1];
   logic [QB-1:0]    quotx_ff[QB+1];
   logic [QB-1:0]    quoty_ff[QB+1];

   logic [CMP_W-1:0] lim_in;
   assign lim_in = CMP_W'({a_den_ff, {QB{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= a_ctl_ff;
      end
   end

   // quotient of 2^QB or more saturates either way
   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]   <= a_den_ff;
         negx_ff[0]  <= a_negx_ff;
         negy_ff[0]  <= a_negy_ff;
         ovfx_ff[0]  <= CMP_W'(a_magx_ff) >= lim_in;
         ovfy_ff[0]  <= CMP_W'(a_magy_ff) >= lim_in;
         remx_ff[0]  <= REM_W'(a_magx_ff);
         remy_ff[0]  <= REM_W'(a_magy_ff);
         quotx_ff[0] <= '0;
         quoty_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic [REM_W-1:0] sub_in;
      logic             gex_in, gey_in;

      assign sub_in = REM_W'(den_ff[k]) << (QB - 1 - k);
      assign gex_in = remx_ff[k] >= sub_in;
      assign gey_in = remy_ff[k] >= sub_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1] <= '0;
         end else if (en) begin
            ctl_ff[k+1] <= ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1]   <= den_ff[k];
            negx_ff[k+1]  <= negx_ff[k];
            negy_ff[k+1]  <= negy_ff[k];
            ovfx_ff[k+1]  <= ovfx_ff[k];
            ovfy_ff[k+1]  <= ovfy_ff[k];
            remx_ff[k+1]  <= gex_in ? remx_ff[k] - sub_in : remx_ff[k];
            remy_ff[k+1]  <= gey_in ? remy_ff[k] - sub_in : remy_ff[k];
            quotx_ff[k+1] <= {quotx_ff[k][QB-2:0], gex_in};
            quoty_ff[k+1] <= {quoty_ff[k][QB-2:0], gey_in};
         end
      end
   end

   // stage C: sign, saturation, behind-viewer override
   vtp_ctl_type c_ctl_ff;
   screen_type  c_scr_x_ff, c_scr_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else if (en) begin
         c_ctl_ff <= ctl_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (ctl_ff[QB].behind) begin
            c_scr_x_ff <= '0;
            c_scr_y_ff <= '0;
         end else begin
            c_scr_x_ff <= sat_quot(negx_ff[QB], ovfx_ff[QB], quotx_ff[QB]);
            c_scr_y_ff <= sat_quot(negy_ff[QB], ovfy_ff[QB], quoty_ff[QB]);
         end
      end
   end

   assign out_ctl   = c_ctl_ff;
   assign out_scr_x = c_scr_x_ff;
   assign out_scr_y = c_scr_y_ff;

   // remainder below the divisor once all bits are resolved
   assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QB].valid && !ctl_ff[QB].behind && !ovfx_ff[QB]
      |-> remx_ff[QB] < REM_W'(den_ff[QB]))
      else $error("vtp_div: x remainder not reduced below divisor");

   assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QB].valid && !ctl_ff[QB].behind && !ovfy_ff[QB]
      |-> remy_ff[QB] < REM_W'(den_ff[QB]))
      else $error("vtp_div: y remainder not reduced below divisor");

   // a nonnegative x numerator never yields a negative x pixel
   assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QB].valid && en && !negx_ff[QB] |=> !c_scr_x_ff[SCREEN_W-1])
      else $error("vtp_div: sign flip on x");

endmodule

### design/view_transform_and_project.sv
// Channel   Dir   Beat                                   Handshake
// req       in    px, py, pz (signed Q15.8)              req_valid / req_ready
// rsp       out   screen_x, screen_y, behind_viewer      rsp_valid / rsp_ready
// csr       in    csr_index, csr_wdata (register write)  csr_valid / csr_ready (always 1)
//
// One beat per clock while the pipeline is not held. From accept to rsp_valid a beat passes 5 stages of
// transform and projection multiply-add, then 19 divider stages (magnitude, range
// check, one quotient bit per stage for 16 bits, saturation), then the output register.
// Reset clears the valid bits and loads the identity matrix, zero offset, focal 80
// and center (320, 240). A stalled output fills a one-beat skid register; req_ready
// drops and the whole pipeline holds only while that skid register is full.
module view_transform_and_project #(
   parameter int COEF_FRAC_BITS = vtp_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  vtp_pkg::coord_type     req_px,
   input  vtp_pkg::coord_type     req_py,
   input  vtp_pkg::coord_type     req_pz,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vtp_pkg::screen_type    rsp_screen_x,
   output vtp_pkg::screen_type    rsp_screen_y,
   output logic                   rsp_behind_viewer,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  vtp_pkg::csr_idx_type   csr_index,
   input  vtp_pkg::csr_data_type  csr_wdata
);
   import vtp_pkg::*;

   localparam int OFF_SH_W = OFF_W + COEF_FRAC_BITS;
   localparam int VW = ((PROD_W > OFF_SH_W) ? PROD_W : OFF_SH_W) + 2;
   localparam int NW = VW + CENTER_W + 1;
   localparam int DW = VW - 1;

   // ---------------- config registers
   logic [WGT_ROW_W-1:0] wgt_ff [3];
   logic [OFF_ROW_W-1:0] off_ff;
   logic [FOCAL_W-1:0]   focal_ff;
   logic [CENTER_W-1:0]  ctr_x_ff, ctr_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wgt_ff[0] <= WEIGHTS_X_RST;
         wgt_ff[1] <= WEIGHTS_Y_RST;
         wgt_ff[2] <= WEIGHTS_Z_RST;
         off_ff    <= OFFSET_RST;
         focal_ff  <= FOCAL_RST;
         ctr_x_ff  <= CENTER_X_RST;
         ctr_y_ff  <= CENTER_Y_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WEIGHTS_X: wgt_ff[0] <= csr_wdata[WGT_ROW_W-1:0];
            REG_WEIGHTS_Y: wgt_ff[1] <= csr_wdata[WGT_ROW_W-1:0];
            REG_WEIGHTS_Z: wgt_ff[2] <= csr_wdata[WGT_ROW_W-1:0];
            REG_OFFSET:    off_ff    <= csr_wdata[OFF_ROW_W-1:0];
            REG_FOCAL:     focal_ff  <= csr_wdata[FOCAL_W-1:0];
            REG_CENTER_X:  ctr_x_ff  <= csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y:  ctr_y_ff  <= csr_wdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline enable
   logic en;
   logic skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   // ---------------- S1..S3: matrix and offset
   logic                     s1_v_ff, s2_v_ff, s3_v_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [VW-1:0]     part_a_ff [3];
   logic signed [VW-1:0]     part_b_ff [3];
   logic signed [VW-1:0]     view_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      logic signed [WGT_W-1:0] w_x, w_y, w_z;
      logic signed [OFF_W-1:0] ofs;

      assign w_x = $signed(wgt_ff[r][0*WGT_W +: WGT_W]);
      assign w_y = $signed(wgt_ff[r][1*WGT_W +: WGT_W]);
      assign w_z = $signed(wgt_ff[r][2*WGT_W +: WGT_W]);
      assign ofs = $signed(off_ff[r*OFF_W +: OFF_W]);

      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[r][0] <= PROD_W'(req_px) * PROD_W'(w_x);
            prod_ff[r][1] <= PROD_W'(req_py) * PROD_W'(w_y);
            prod_ff[r][2] <= PROD_W'(req_pz) * PROD_W'(w_z);
            part_a_ff[r]  <= VW'(prod_ff[r][0]) + VW'(prod_ff[r][1]);
            part_b_ff[r]  <= VW'(prod_ff[r][2]) + (VW'(ofs) <<< COEF_FRAC_BITS);
            view_ff[r]    <= part_a_ff[r] + part_b_ff[r];
         end
      end
   end

   // ---------------- S4, S5: projection numerators
   vtp_ctl_type          s4_ctl_ff, s5_ctl_ff;
   logic signed [NW-1:0] cxz_ff, cyz_ff, fvx_ff, fvy_ff;
   logic [DW-1:0]        s4_den_ff, s5_den_ff;
   logic signed [NW-1:0] nx_ff, ny_ff;
   vtp_ctl_type          s4_ctl_in;

   assign s4_ctl_in.valid  = s3_v_ff;
   assign s4_ctl_in.behind = view_ff[2][VW-1] || (view_ff[2] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
      end else if (en) begin
         s4_ctl_ff <= s4_ctl_in;
         s5_ctl_ff <= s4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cxz_ff    <= NW'($signed({1'b0, ctr_x_ff})) * NW'(view_ff[2]);
         cyz_ff    <= NW'($signed({1'b0, ctr_y_ff})) * NW'(view_ff[2]);
         fvx_ff    <= NW'($signed({1'b0, focal_ff})) * NW'(view_ff[0]);
         fvy_ff    <= NW'($signed({1'b0, focal_ff})) * NW'(view_ff[1]);
         s4_den_ff <= view_ff[2][DW-1:0];
         nx_ff     <= cxz_ff + fvx_ff;
         ny_ff     <= cyz_ff - fvy_ff;
         s5_den_ff <= s4_den_ff;
      end
   end

   // ---------------- divide and saturate
   vtp_ctl_type div_ctl;
   screen_type  div_x, div_y;

   vtp_div #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (s5_ctl_ff),
      .in_num_x  (nx_ff),
      .in_num_y  (ny_ff),
      .in_den    (s5_den_ff),
      .out_ctl   (div_ctl),
      .out_scr_x (div_x),
      .out_scr_y (div_y)
   );

   // ---------------- output register and skid
   logic       out_v_ff;
   screen_type out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic       out_b_ff, skid_b_ff;
   logic       arrive_in, out_free_in;

   assign arrive_in   = en && div_ctl.valid;
   assign out_free_in = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_free_in) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (arrive_in) begin
         if (out_free_in) out_v_ff <= 1'b1;
         else             skid_v_ff <= 1'b1;
      end else if (out_free_in) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_free_in) begin
            out_x_ff <= skid_x_ff;
            out_y_ff <= skid_y_ff;
            out_b_ff <= skid_b_ff;
         end
      end else if (arrive_in) begin
         if (out_free_in) begin
            out_x_ff <= div_x;
            out_y_ff <= div_y;
            out_b_ff <= div_ctl.behind;
         end else begin
            skid_x_ff <= div_x;
            skid_y_ff <= div_y;
            skid_b_ff <= div_ctl.behind;
         end
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_screen_x      = out_x_ff;
   assign rsp_screen_y      = out_y_ff;
   assign rsp_behind_viewer = out_b_ff;

   assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("vtp: skid holds a beat while output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && !rsp_ready |=> skid_v_ff && !req_ready)
      else $error("vtp: skid beat lost during stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_behind_viewer |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("vtp: behind-viewer beat with nonzero coordinates");

endmodule

### bench/screen_point_checker.sv
module screen_point_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  vtp_pkg::coord_type    req_px,
   input  vtp_pkg::coord_type    req_py,
   input  vtp_pkg::coord_type    req_pz,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  vtp_pkg::screen_type   rsp_screen_x,
   input  vtp_pkg::screen_type   rsp_screen_y,
   input  logic                  rsp_behind_viewer,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  vtp_pkg::csr_idx_type  csr_index,
   input  vtp_pkg::csr_data_type csr_wdata,
   output int                    mismatches,
   output int                    pending
);
   import vtp_pkg::*;

   typedef struct {
      screen_type sx;
      screen_type sy;
      logic       behind;
   } screen_point_type;

   screen_point_type projected_points[$];

   logic [WGT_ROW_W-1:0] row_x, row_y, row_z;
   logic [OFF_ROW_W-1:0] offsets;
   logic [FOCAL_W-1:0]   focal;
   logic [CENTER_W-1:0]  center_x, center_y;

   // one view coordinate, kept exact at coordinate plus weight fraction bits
   function automatic longint view_coord(input logic [WGT_ROW_W-1:0] row,
                                         input logic signed [OFF_W-1:0] shift,
                                         input coord_type x, input coord_type y,
                                         input coord_type z);
      return longint'(x) * longint'($signed(row[WGT_W-1:0]))
           + longint'(y) * longint'($signed(row[2*WGT_W-1:WGT_W]))
           + longint'(z) * longint'($signed(row[3*WGT_W-1:2*WGT_W]))
           + (longint'(shift) <<< COEF_FRAC_BITS_DEF);
   endfunction

   function automatic screen_type clamp_pixel(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return screen_type'(v);
   endfunction

   function automatic screen_point_type project_point(input coord_type x,
                                                      input coord_type y,
                                                      input coord_type z);
      screen_point_type p;
      longint vx, vy, vz;
      vx = view_coord(row_x, offsets[OFF_W-1:0], x, y, z);
      vy = view_coord(row_y, offsets[2*OFF_W-1:OFF_W], x, y, z);
      vz = view_coord(row_z, offsets[3*OFF_W-1:2*OFF_W], x, y, z);
      p.behind = (vz <= 0);
      if (p.behind) begin
         p.sx = '0;
         p.sy = '0;
      end else begin
         // signed division truncates toward zero, so the quotient is rounded once
         p.sx = clamp_pixel((longint'(center_x) * vz + longint'(focal) * vx) / vz);
         p.sy = clamp_pixel((longint'(center_y) * vz - longint'(focal) * vy) / vz);
      end
      return p;
   endfunction

   always @(posedge clock) begin : watch
      screen_point_type want;
      if (reset) begin
         row_x    <= WEIGHTS_X_RST;
         row_y    <= WEIGHTS_Y_RST;
         row_z    <= WEIGHTS_Z_RST;
         offsets  <= OFFSET_RST;
         focal    <= FOCAL_RST;
         center_x <= CENTER_X_RST;
         center_y <= CENTER_Y_RST;
         mismatches <= 0;
         pending    <= 0;
         projected_points.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (projected_points.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result beat with nothing pending: x=%0d y=%0d behind=%0b",
                           $time, rsp_screen_x, rsp_screen_y, rsp_behind_viewer);
               mismatches <= mismatches + 1;
            end else begin
               want = projected_points.pop_front();
               if (rsp_screen_x !== want.sx || rsp_screen_y !== want.sy ||
                   rsp_behind_viewer !== want.behind) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: expected x=%0d y=%0d behind=%0b, got x=%0d y=%0d behind=%0b",
                              $time, want.sx, want.sy, want.behind,
                              rsp_screen_x, rsp_screen_y, rsp_behind_viewer);
                  mismatches <= mismatches + 1;
               end
            end
         end
         // config takes effect after this edge, so this beat sees the old values
         if (req_valid && req_ready)
            projected_points.push_back(project_point(req_px, req_py, req_pz));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WEIGHTS_X: row_x    <= csr_wdata[WGT_ROW_W-1:0];
               REG_WEIGHTS_Y: row_y    <= csr_wdata[WGT_ROW_W-1:0];
               REG_WEIGHTS_Z: row_z    <= csr_wdata[WGT_ROW_W-1:0];
               REG_OFFSET:    offsets  <= csr_wdata[OFF_ROW_W-1:0];
               REG_FOCAL:     focal    <= csr_wdata[FOCAL_W-1:0];
               REG_CENTER_X:  center_x <= csr_wdata[CENTER_W-1:0];
               REG_CENTER_Y:  center_y <= csr_wdata[CENTER_W-1:0];
               default: ;
            endcase
         end
         pending <= projected_points.size();
      end
   end

endmodule

### bench/view_transform_and_project_tb.sv
module view_transform_and_project_tb;
   import vtp_pkg::*;

   localparam int          NUM_PHASES     = 6;
   localparam int          POINTS_PER_SET = 300;
   localparam int          SETTLE_CYCLES  = 30;
   localparam int          HOLD_CYCLES    = 200;
   localparam int unsigned CYCLE_LIMIT    = 200000;

   localparam coord_type CMAX = 24'sh7FFFFF;
   localparam coord_type CMIN = 24'sh800000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   coord_type    req_px = '0;
   coord_type    req_py = '0;
   coord_type    req_pz = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   screen_type   rsp_screen_x;
   screen_type   rsp_screen_y;
   logic         rsp_behind_viewer;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   csr_idx_type  csr_index = '0;
   csr_data_type csr_wdata = '0;

   int           mismatches;
   int           pending;
   int           send_idle_pct = 35;
   int           recv_idle_pct = 59;
   logic         hold_off = 1'b0;
   logic         squeeze = 1'b0;
   int unsigned  cycle_count = 0;

   view_transform_and_project DUT (.*);
   screen_point_checker point_check (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

   // long output stall so the pipeline and skid fill and req_ready drops
   initial begin : long_stall
      wait (squeeze);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic send_point(input coord_type x, input coord_type y, input coord_type z);
      req_valid <= 1'b1;
      req_px    <= x;
      req_py    <= y;
      req_pz    <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_random_point();
      coord_type x, y, z;
      if ($urandom_range(99) < 60) begin
         // points in a modest scene, mostly in front of the default camera
         x = coord_type'($signed(18'($urandom)));
         y = coord_type'($signed(18'($urandom)));
         z = coord_type'($urandom_range(1 << 17, 1));
         if ($urandom_range(9) == 0) z = -z;
      end else begin
         x = coord_type'($urandom);
         y = coord_type'($urandom);
         z = coord_type'($urandom);
      end
      send_point(x, y, z);
   endtask

   task automatic write_reg(input csr_idx_type idx, input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [WGT_W-1:0] pick_weight(input bit on_diag);
      if (on_diag) return WGT_W'($urandom_range(16'h5000, 16'h2000));
      return WGT_W'($signed(12'($urandom)));
   endfunction

   function automatic csr_data_type wide_random();
      return csr_data_type'({$urandom, $urandom});
   endfunction

   task automatic load_view(input int phase);
      case (phase)
         0: begin
            // extreme weights, offsets and screen geometry
            write_reg(REG_WEIGHTS_X, 60'h000_7FFF_8000_7FFF);
            write_reg(REG_WEIGHTS_Y, 60'hFFF_8000_7FFF_8000);
            write_reg(REG_WEIGHTS_Z, 60'h000_7FFF_0001_FFFF);
            write_reg(REG_OFFSET, {20'h7FFFF, 20'h80000, 20'h7FFFF});
            write_reg(REG_FOCAL, 60'd1023);
            write_reg(REG_CENTER_X, 60'hFFF);
            write_reg(REG_CENTER_Y, 60'hFFF);
            write_reg(csr_idx_type'(NUM_REGS), '1);
         end
         1: begin
            // zero focal length: every visible point lands on the center
            write_reg(REG_WEIGHTS_X, 60'h000_8000_8000_8000);
            write_reg(REG_WEIGHTS_Y, 60'h000_7FFF_7FFF_7FFF);
            write_reg(REG_WEIGHTS_Z, 60'h000_4000_0000_0000);
            write_reg(REG_OFFSET, {20'h00100, 20'h80000, 20'h80000});
            write_reg(REG_FOCAL, 60'hFFF_FFFF_FFFF_FC00);
            write_reg(REG_CENTER_X, 60'h0);
            write_reg(REG_CENTER_Y, 60'h800);
         end
         default: begin
            if (phase % 2 == 0) begin
               write_reg(REG_WEIGHTS_X, wide_random());
               write_reg(REG_WEIGHTS_Y, wide_random());
               write_reg(REG_WEIGHTS_Z, wide_random());
               write_reg(REG_OFFSET, wide_random());
               write_reg(REG_FOCAL, wide_random());
               write_reg(REG_CENTER_X, wide_random());
               write_reg(REG_CENTER_Y, wide_random());
               write_reg(csr_idx_type'(NUM_REGS), wide_random());
            end else begin
               // near-rotation camera with small offsets
               write_reg(REG_WEIGHTS_X, csr_data_type'({pick_weight(1'b0), pick_weight(1'b0),
                                                        pick_weight(1'b1)}));
               write_reg(REG_WEIGHTS_Y, csr_data_type'({pick_weight(1'b0), pick_weight(1'b1),
                                                        pick_weight(1'b0)}));
               write_reg(REG_WEIGHTS_Z, csr_data_type'({pick_weight(1'b1), pick_weight(1'b0),
                                                        pick_weight(1'b0)}));
               write_reg(REG_OFFSET, {20'($signed(14'($urandom))),
                                      20'($signed(14'($urandom))),
                                      20'($signed(14'($urandom)))});
               write_reg(REG_FOCAL, csr_data_type'($urandom_range(1023, 1)));
               write_reg(REG_CENTER_X, csr_data_type'($urandom_range(4095)));
               write_reg(REG_CENTER_Y, csr_data_type'($urandom_range(4095)));
            end
         end
      endcase
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // identity view, focal 80, center (320, 240)
      send_point(0, 0, 256);
      send_point(256, 256, 256);
      send_point(-256, 128, 512);
      send_point(0, 0, 0);
      send_point(0, 0, -1);
      send_point(0, 0, 1);
      send_point(CMAX, CMAX, 1);
      send_point(CMIN, CMIN, 1);
      send_point(CMAX, CMIN, CMAX);
      send_point(CMIN, CMAX, CMAX);
      send_point(CMIN, CMIN, CMIN);
      send_point(CMAX, CMAX, CMIN);
      send_point(-1025, 0, 256);
      send_point(-1281, 1281, 256);
      send_point(24'sh555555, 24'shAAAAAA, 24'sh2AAAAA);
      send_point(24'shAAAAAA, 24'sh555555, 24'sh555555);
      send_point(CMAX, 0, 256);
      send_point(0, CMIN, 256);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_valid <= 1'b0;
         drain();
         if (phase == 2) begin
            send_idle_pct = 59;
            recv_idle_pct <= 35;
         end
         if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         load_view(phase);
         if (phase == 4) squeeze <= 1'b1;
         repeat (POINTS_PER_SET) send_random_point();
      end
      req_valid <= 1'b0;
      drain();

      if (mismatches == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
